@@ rtl/core/box_nms_suppress_macros.svh @@
// assertion macros for the box_nms_suppress block
// no dependencies; included by modules that carry assertions
`ifndef BOX_NMS_SUPPRESS_MACROS_SVH
`define BOX_NMS_SUPPRESS_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is held
`define BNMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define BNMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BNMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BNMS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/bnms_pkg.sv @@
// shared constants and controller/datapath command types for box_nms_suppress
// no dependencies
package bnms_pkg;

    localparam int IDX_W           = 6;
    localparam int SCORE_W         = 16;
    localparam int FIELD_W         = 16;
    localparam int MAX_DETS_DEF    = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam logic [15:0] THRESH_RESET = 16'd29491;

    // commands from controller to datapath
    typedef struct packed {
        logic             ld_we;      // store incoming box and score at wr_addr
        logic [IDX_W-1:0] wr_addr;
        logic             sc_rd;      // read box, score, flag memories
        logic             rd_use_ord; // read address comes from order read data
        logic [IDX_W-1:0] rd_addr;
        logic             ord_rd;     // read order memory at rd_addr
        logic [IDX_W-1:0] i_idx;      // outer loop index
        logic             key_ld;
        logic             rank_clr;
        logic             cmp_en;
        logic             ord_we;     // order[rank] = i_idx, clear flag of i_idx
        logic             a_ld;       // latch reference box
        logic             sup_en;     // apply suppression decision
        logic             emit;
        logic             ovf;
        logic             last;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic a_zero;
    } t_stat;

endpackage

@@ rtl/core/bnms_dp.sv @@
// datapath for box_nms_suppress: detection memories, rank counter, iou pipeline
// depends on bnms_pkg
module bnms_dp #(
    parameter int MAX_DETS    = bnms_pkg::MAX_DETS_DEF,
    parameter int COORD_WIDTH = bnms_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bnms_pkg::t_cmd                 i_cmd,
    output bnms_pkg::t_stat                o_stat,
    input  logic [bnms_pkg::FIELD_W-1:0]   i_center_x,
    input  logic [bnms_pkg::FIELD_W-1:0]   i_center_y,
    input  logic [bnms_pkg::FIELD_W-1:0]   i_box_width,
    input  logic [bnms_pkg::FIELD_W-1:0]   i_box_height,
    input  logic [bnms_pkg::SCORE_W-1:0]   i_class_score,
    input  logic                           i_cfg_wr_en,
    input  logic [15:0]                    i_cfg_wr_data,
    output logic [bnms_pkg::IDX_W-1:0]     o_det_index,
    output logic [bnms_pkg::SCORE_W-1:0]   o_score_out,
    output logic                           o_was_suppressed,
    output logic                           o_overflowed,
    output logic                           o_run_end
);

    localparam int CW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int IW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int BW = 4 * CW;
    localparam int EW = CW + 3;       // signed doubled edge
    localparam int OW = CW + 2;       // overlap magnitude
    localparam int XW = 2 * OW;       // intersection
    localparam int AW = 2 * CW;       // single area
    localparam int UW = 2 * CW + 3;   // union
    localparam int PW = UW + 16;      // threshold times union
    localparam int LW = XW + 16;      // compare width

    // memories
    logic [BW-1:0]               box_mem [MAX_DETS];
    logic [bnms_pkg::SCORE_W-1:0] sc_mem [MAX_DETS];
    logic [IW-1:0]               ord_mem [MAX_DETS];
    logic                        supp_mem [MAX_DETS];

    logic [BW-1:0]               r_box_q;
    logic [bnms_pkg::SCORE_W-1:0] r_sc_q;
    logic                        r_supp_q;
    logic [IW-1:0]               r_ord_q;
    logic [bnms_pkg::IDX_W-1:0]  r_sc_raddr;
    logic [BW-1:0]               r_a_box;
    logic [bnms_pkg::SCORE_W-1:0] r_key;
    logic [bnms_pkg::IDX_W-1:0]  r_rank;
    logic [15:0]                 r_thresh;

    logic [IW-1:0] rd_a;
    logic          sup_hit;
    logic          sup_wr;
    logic          rank_hit;

    assign rd_a   = i_cmd.rd_use_ord ? r_ord_q : i_cmd.rd_addr[IW-1:0];
    assign sup_wr = i_cmd.sup_en & sup_hit;
    assign o_stat.a_zero = (r_sc_q == '0);

    // memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_rd) begin
            r_box_q    <= box_mem[rd_a];
            r_sc_q     <= sc_mem[rd_a];
            r_supp_q   <= supp_mem[rd_a];
            r_sc_raddr <= i_cmd.rd_addr;
        end
        if (i_cmd.ord_rd) begin
            r_ord_q <= ord_mem[i_cmd.rd_addr[IW-1:0]];
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_we) begin
            box_mem[i_cmd.wr_addr[IW-1:0]] <= {i_center_x[CW-1:0], i_center_y[CW-1:0],
                                               i_box_width[CW-1:0], i_box_height[CW-1:0]};
            sc_mem[i_cmd.wr_addr[IW-1:0]]  <= i_class_score;
        end else if (sup_wr) begin
            sc_mem[r_ord_q] <= '0;
        end
        if (i_cmd.ord_we) begin
            ord_mem[r_rank[IW-1:0]]      <= i_cmd.i_idx[IW-1:0];
            supp_mem[i_cmd.i_idx[IW-1:0]] <= 1'b0;
        end else if (sup_wr && (r_sc_q != '0)) begin
            supp_mem[r_ord_q] <= 1'b1;
        end
    end

    // rank counting for the stable descending sort
    assign rank_hit = (r_sc_q > r_key) || ((r_sc_q == r_key) && (r_sc_raddr < i_cmd.i_idx));

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_ld) begin
            r_key <= r_sc_q;
        end
        if (i_cmd.rank_clr) begin
            r_rank <= '0;
        end else if (i_cmd.cmp_en && rank_hit) begin
            r_rank <= r_rank + 1'b1;
        end
        if (i_cmd.a_ld) begin
            r_a_box <= r_box_q;
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= bnms_pkg::THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    // iou stage 1: overlaps on doubled coordinates
    logic [CW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    logic signed [EW-1:0] lo_ax, hi_ax, lo_bx, hi_bx, lo_ay, hi_ay, lo_by, hi_by;
    logic signed [EW-1:0] ow_s, oh_s;

    assign {ax, ay, aw, ah} = r_a_box;
    assign {bx, by, bw, bh} = r_box_q;

    always_comb begin
        lo_ax = $signed({2'b00, ax, 1'b0}) - $signed({3'b000, aw});
        hi_ax = $signed({2'b00, ax, 1'b0}) + $signed({3'b000, aw});
        lo_bx = $signed({2'b00, bx, 1'b0}) - $signed({3'b000, bw});
        hi_bx = $signed({2'b00, bx, 1'b0}) + $signed({3'b000, bw});
        lo_ay = $signed({2'b00, ay, 1'b0}) - $signed({3'b000, ah});
        hi_ay = $signed({2'b00, ay, 1'b0}) + $signed({3'b000, ah});
        lo_by = $signed({2'b00, by, 1'b0}) - $signed({3'b000, bh});
        hi_by = $signed({2'b00, by, 1'b0}) + $signed({3'b000, bh});
        ow_s  = ((hi_ax < hi_bx) ? hi_ax : hi_bx) - ((lo_ax > lo_bx) ? lo_ax : lo_bx);
        oh_s  = ((hi_ay < hi_by) ? hi_ay : hi_by) - ((lo_ay > lo_by) ? lo_ay : lo_by);
    end

    logic [OW-1:0] r_ow, r_oh;
    logic          r_ov_ok;
    logic [XW-1:0] r_inter, r_inter2;
    logic [AW-1:0] r_area_a, r_area_b;
    logic [UW-1:0] r_uni;
    logic          r_zu, r_zu2;
    logic [PW-1:0] r_prod;
    logic [LW-1:0] r_inter_sh;
    logic [XW-1:0] areas;

    assign areas = XW'({r_area_a, 2'b00}) + XW'({r_area_b, 2'b00});

    // iou stages 2 to 4: products, union, threshold product
    always_ff @(posedge i_clk) begin
        r_ow       <= ow_s[OW-1:0];
        r_oh       <= oh_s[OW-1:0];
        r_ov_ok    <= !ow_s[EW-1] && !oh_s[EW-1];
        r_inter    <= r_ov_ok ? (XW'(r_ow) * XW'(r_oh)) : '0;
        r_area_a   <= AW'(aw) * AW'(ah);
        r_area_b   <= AW'(bw) * AW'(bh);
        r_zu       <= (areas <= r_inter);
        r_uni      <= UW'(areas - r_inter);
        r_inter2   <= r_inter;
        r_zu2      <= r_zu;
        r_prod     <= PW'(r_thresh) * PW'(r_uni);
        r_inter_sh <= {r_inter2, 16'h0000};
    end

    assign sup_hit = !r_zu2 && (r_inter_sh > LW'(r_prod));

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_det_index      <= bnms_pkg::IDX_W'(r_ord_q);
            o_score_out      <= r_sc_q;
            o_was_suppressed <= r_supp_q;
            o_overflowed     <= i_cmd.ovf;
            o_run_end        <= i_cmd.last;
        end
    end

endmodule

@@ rtl/core/bnms_ctrl.sv @@
// controller for box_nms_suppress: load, rank sort, pairwise suppression, result scan
// depends on bnms_pkg and box_nms_suppress_macros.svh
`include "box_nms_suppress_macros.svh"
module bnms_ctrl #(
    parameter int MAX_DETS = bnms_pkg::MAX_DETS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            i_is_final,
    input  bnms_pkg::t_stat i_stat,
    output bnms_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_result_valid
);

    localparam int CNT_W = $clog2(MAX_DETS + 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_KEY     = 15'b000000000000010,
        S_SCAN    = 15'b000000000000100,
        S_PLACE   = 15'b000000000001000,
        S_RANK_WR = 15'b000000000010000,
        S_A_ORD   = 15'b000000000100000,
        S_A_BOX   = 15'b000000001000000,
        S_A_LAT   = 15'b000000010000000,
        S_B_ORD   = 15'b000000100000000,
        S_B_BOX   = 15'b000001000000000,
        S_B_WAIT  = 15'b000010000000000,
        S_B_DEC   = 15'b000100000000000,
        S_O_ORD   = 15'b001000000000000,
        S_O_RD    = 15'b010000000000000,
        S_O_EMIT  = 15'b100000000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [1:0]       r_wait, n_wait;
    logic             r_ovf, n_ovf;
    logic             r_valid;
    logic [CNT_W-1:0] i_nx, j_nx;
    logic             i_last;

    assign i_nx   = r_i + CNT_W'(1);
    assign j_nx   = r_j + CNT_W'(1);
    assign i_last = (i_nx == r_cnt);
    assign busy   = (r_state != S_IDLE);
    assign o_result_valid = r_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_wait  = r_wait;
        n_ovf   = r_ovf;
        o_cmd   = '0;
        o_cmd.i_idx = bnms_pkg::IDX_W'(r_i);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_cnt < CNT_W'(MAX_DETS)) begin
                        o_cmd.ld_we   = 1'b1;
                        o_cmd.wr_addr = bnms_pkg::IDX_W'(r_cnt);
                        n_cnt         = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_final) begin
                        n_i     = '0;
                        n_state = S_KEY;
                    end
                end
            end
            S_KEY: begin
                o_cmd.sc_rd    = 1'b1;
                o_cmd.rd_addr  = bnms_pkg::IDX_W'(r_i);
                o_cmd.rank_clr = 1'b1;
                n_j            = '0;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.sc_rd   = 1'b1;
                o_cmd.rd_addr = bnms_pkg::IDX_W'(r_j);
                o_cmd.key_ld  = (r_j == '0);
                o_cmd.cmp_en  = (r_j != '0);
                n_j           = j_nx;
                if (j_nx == r_cnt) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.cmp_en = 1'b1;
                n_state      = S_RANK_WR;
            end
            S_RANK_WR: begin
                o_cmd.ord_we = 1'b1;
                if (i_last) begin
                    n_i     = '0;
                    n_state = S_A_ORD;
                end else begin
                    n_i     = i_nx;
                    n_state = S_KEY;
                end
            end
            S_A_ORD: begin
                o_cmd.ord_rd  = 1'b1;
                o_cmd.rd_addr = bnms_pkg::IDX_W'(r_i);
                n_state       = S_A_BOX;
            end
            S_A_BOX: begin
                o_cmd.sc_rd      = 1'b1;
                o_cmd.rd_use_ord = 1'b1;
                n_state          = S_A_LAT;
            end
            S_A_LAT: begin
                o_cmd.a_ld = 1'b1;
                if (i_stat.a_zero || i_last) begin
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_O_ORD;
                    end else begin
                        n_i     = i_nx;
                        n_state = S_A_ORD;
                    end
                end else begin
                    n_j     = i_nx;
                    n_state = S_B_ORD;
                end
            end
            S_B_ORD: begin
                o_cmd.ord_rd  = 1'b1;
                o_cmd.rd_addr = bnms_pkg::IDX_W'(r_j);
                n_state       = S_B_BOX;
            end
            S_B_BOX: begin
                o_cmd.sc_rd      = 1'b1;
                o_cmd.rd_use_ord = 1'b1;
                n_wait           = '0;
                n_state          = S_B_WAIT;
            end
            S_B_WAIT: begin
                n_wait = r_wait + 2'd1;
                if (r_wait == 2'd3) begin
                    n_state = S_B_DEC;
                end
            end
            S_B_DEC: begin
                o_cmd.sup_en = 1'b1;
                if (j_nx == r_cnt) begin
                    if (i_last) begin
                        n_i     = '0;
                        n_state = S_O_ORD;
                    end else begin
                        n_i     = i_nx;
                        n_state = S_A_ORD;
                    end
                end else begin
                    n_j     = j_nx;
                    n_state = S_B_ORD;
                end
            end
            S_O_ORD: begin
                o_cmd.ord_rd  = 1'b1;
                o_cmd.rd_addr = bnms_pkg::IDX_W'(r_i);
                n_state       = S_O_RD;
            end
            S_O_RD: begin
                o_cmd.sc_rd      = 1'b1;
                o_cmd.rd_use_ord = 1'b1;
                n_state          = S_O_EMIT;
            end
            S_O_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.ovf  = r_ovf;
                o_cmd.last = i_last;
                if (i_last) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_i     = i_nx;
                    n_state = S_O_ORD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_wait  <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_wait  <= n_wait;
            r_ovf   <= n_ovf;
            r_valid <= o_cmd.emit;
        end
    end

    // checks
    `BNMS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_DETS), "load count past capacity")
    `BNMS_ASSERT(a_emit_nonempty, i_clk, i_rst_n, o_cmd.emit |-> (r_cnt != '0), "result with empty run")
    `BNMS_ASSERT(a_final_busy, i_clk, i_rst_n, (start && !busy && i_is_final) |=> busy, "final transaction did not start a run")
    `BNMS_ASSERT(a_last_idle, i_clk, i_rst_n, (o_cmd.emit && o_cmd.last) |=> !busy, "run did not end after last result")

endmodule

@@ rtl/core/box_nms_suppress.sv @@
// top level of box_nms_suppress: greedy non-maximum suppression for one class
// depends on bnms_pkg, bnms_ctrl, bnms_dp
//
// Each transaction (start while busy is low) loads one box and its score; busy stays
// low while loading. The transaction marked is_final starts the run: busy rises, the
// detections are ranked by score (one score memory read per cycle), then every live
// box is checked against each later box through the iou pipeline, then one result per
// detection is put out, each valid for one cycle on o_result_valid. The receiver
// cannot stall; busy falls as the last result is issued.
module box_nms_suppress #(
    parameter int MAX_DETS    = bnms_pkg::MAX_DETS_DEF,
    parameter int COORD_WIDTH = bnms_pkg::COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bnms_pkg::FIELD_W-1:0] i_center_x,
    input  logic [bnms_pkg::FIELD_W-1:0] i_center_y,
    input  logic [bnms_pkg::FIELD_W-1:0] i_box_width,
    input  logic [bnms_pkg::FIELD_W-1:0] i_box_height,
    input  logic [bnms_pkg::SCORE_W-1:0] i_class_score,
    input  logic                         i_is_final,
    input  logic                         i_cfg_wr_en,
    input  logic [15:0]                  i_cfg_wr_data,
    output logic                         o_result_valid,
    output logic [bnms_pkg::IDX_W-1:0]   o_det_index,
    output logic [bnms_pkg::SCORE_W-1:0] o_score_out,
    output logic                         o_was_suppressed,
    output logic                         o_overflowed,
    output logic                         o_run_end
);

    bnms_pkg::t_cmd  cmd;
    bnms_pkg::t_stat stat;

    // sequencer
    bnms_ctrl #(
        .MAX_DETS(MAX_DETS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_is_final    (i_is_final),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .busy          (busy),
        .o_result_valid(o_result_valid)
    );

    // memories and arithmetic
    bnms_dp #(
        .MAX_DETS   (MAX_DETS),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_box_width     (i_box_width),
        .i_box_height    (i_box_height),
        .i_class_score   (i_class_score),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_det_index     (o_det_index),
        .o_score_out     (o_score_out),
        .o_was_suppressed(o_was_suppressed),
        .o_overflowed    (o_overflowed),
        .o_run_end       (o_run_end)
    );

endmodule

@@ verif/box_nms_suppress_tb.sv @@
// self-checking testbench for box_nms_suppress: greedy nms over loaded boxes
// depends on bnms_pkg and the box_nms_suppress rtl; predicts each run in software
module box_nms_suppress_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DETS = bnms_pkg::MAX_DETS_DEF;

    typedef struct {
        logic [15:0] cx, cy, w, h, score;
        logic        fin;
    } t_det;

    typedef struct {
        logic [bnms_pkg::IDX_W-1:0]   idx;
        logic [bnms_pkg::SCORE_W-1:0] score;
        logic                         supp, ovf, last;
    } t_nms_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [15:0] i_center_x = '0, i_center_y = '0, i_box_width = '0, i_box_height = '0;
    logic [15:0] i_class_score = '0;
    logic i_is_final = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic o_result_valid;
    logic [bnms_pkg::IDX_W-1:0] o_det_index;
    logic [bnms_pkg::SCORE_W-1:0] o_score_out;
    logic o_was_suppressed, o_overflowed, o_run_end;

    box_nms_suppress dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_center_x, .i_center_y, .i_box_width, .i_box_height,
        .i_class_score, .i_is_final, .i_cfg_wr_en, .i_cfg_wr_data,
        .o_result_valid, .o_det_index, .o_score_out, .o_was_suppressed,
        .o_overflowed, .o_run_end
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    t_det        run_dets[N_DETS];
    int          run_count = 0;
    logic        run_ovf = 1'b0;
    logic [15:0] iou_thresh = bnms_pkg::THRESH_RESET;

    t_det        pending_dets[$];
    t_nms_out    expected_results[$];
    int          error_count = 0;
    int          sent_count = 0;
    bit          hold_sender = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic longint span_overlap(input logic [15:0] c1, s1, c2, s2);
        longint lo1, lo2, hi1, hi2;
        lo1 = 2 * longint'(c1) - longint'(s1);
        lo2 = 2 * longint'(c2) - longint'(s2);
        hi1 = 2 * longint'(c1) + longint'(s1);
        hi2 = 2 * longint'(c2) + longint'(s2);
        return ((hi1 < hi2) ? hi1 : hi2) - ((lo1 > lo2) ? lo1 : lo2);
    endfunction

    function automatic bit overlap_too_high(input t_det a, input t_det b);
        longint ow, oh;
        logic [63:0] inter, areas, uni;
        ow = span_overlap(a.cx, a.w, b.cx, b.w);
        oh = span_overlap(a.cy, a.h, b.cy, b.h);
        inter = (ow >= 0 && oh >= 0) ? 64'(ow) * 64'(oh) : 64'd0;
        areas = 4 * (64'(a.w) * 64'(a.h) + 64'(b.w) * 64'(b.h));
        if (areas <= inter) return 1'b0;
        uni = areas - inter;
        return (inter * 64'd65536) > (64'(iou_thresh) * uni);
    endfunction

    // load one accepted detection and, on the final one, predict the run
    task automatic predict_nms(input t_det d);
        int order[N_DETS];
        logic [15:0] sc[N_DETS];
        bit supp[N_DETS];
        int j, id, a, b;
        t_nms_out r;
        if (run_count < N_DETS) begin
            run_dets[run_count] = d;
            run_count++;
        end else begin
            run_ovf = 1'b1;
        end
        if (!d.fin) return;
        for (int i = 0; i < run_count; i++) begin
            sc[i] = run_dets[i].score;
            supp[i] = 1'b0;
        end
        // stable sort, high score first
        for (int i = 0; i < run_count; i++) begin
            id = i;
            j = i;
            while (j > 0 && sc[order[j-1]] < sc[id]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = id;
        end
        for (int i = 0; i < run_count; i++) begin
            a = order[i];
            if (sc[a] != 0) begin
                for (int k = i + 1; k < run_count; k++) begin
                    b = order[k];
                    if (overlap_too_high(run_dets[a], run_dets[b])) begin
                        if (sc[b] != 0) supp[b] = 1'b1;
                        sc[b] = '0;
                    end
                end
            end
        end
        for (int i = 0; i < run_count; i++) begin
            r.idx = bnms_pkg::IDX_W'(order[i]);
            r.score = sc[order[i]];
            r.supp = supp[order[i]];
            r.ovf = run_ovf;
            r.last = (i == run_count - 1);
            expected_results.push_back(r);
        end
        run_count = 0;
        run_ovf = 1'b0;
    endtask

    // driver: bursts and gaps, one transaction per accepted edge
    always @(posedge i_clk) begin
        t_det nx;
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_nms(pending_dets.pop_front());
                sent_count++;
            end
            if (start && busy) begin
                // hold current transaction
            end else if (pending_dets.size() > 0 && !hold_sender && !i_cfg_wr_en) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else begin
                    nx = pending_dets[0];
                    start <= 1'b1;
                    i_center_x <= nx.cx;
                    i_center_y <= nx.cy;
                    i_box_width <= nx.w;
                    i_box_height <= nx.h;
                    i_class_score <= nx.score;
                    i_is_final <= nx.fin;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                    end
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, compare each one as it comes
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                t_nms_out e;
                e = expected_results.pop_front();
                if (o_det_index !== e.idx)
                    report_mismatch($sformatf("det_index %0d exp %0d", o_det_index, e.idx));
                if (o_score_out !== e.score)
                    report_mismatch($sformatf("score_out %0h exp %0h", o_score_out, e.score));
                if (o_was_suppressed !== e.supp)
                    report_mismatch($sformatf("was_suppressed %0b exp %0b idx %0d",
                                              o_was_suppressed, e.supp, e.idx));
                if (o_overflowed !== e.ovf)
                    report_mismatch($sformatf("overflowed %0b exp %0b", o_overflowed, e.ovf));
                if (o_run_end !== e.last)
                    report_mismatch($sformatf("run_end %0b exp %0b", o_run_end, e.last));
            end
        end
    end

    function automatic t_det rand_det(input bit fin, input int mode);
        t_det d;
        // clustered boxes make overlaps common; wide mode covers all bits
        if (mode == 0) begin
            d.cx = 16'($urandom_range(900, 1100));
            d.cy = 16'($urandom_range(900, 1100));
            d.w = 16'($urandom_range(100, 400));
            d.h = 16'($urandom_range(100, 400));
        end else begin
            d.cx = 16'($urandom);
            d.cy = 16'($urandom);
            d.w = 16'($urandom);
            d.h = 16'($urandom);
        end
        case ($urandom_range(0, 7))
            0: d.score = '0;
            1: d.score = 16'hffff;
            2: d.score = 16'($urandom_range(1, 4)) * 16'd1000;
            default: d.score = 16'($urandom);
        endcase
        d.fin = fin;
        return d;
    endfunction

    function automatic t_det mk(input logic [15:0] cx, cy, w, h, s, input bit fin);
        t_det d;
        d.cx = cx; d.cy = cy; d.w = w; d.h = h; d.score = s; d.fin = fin;
        return d;
    endfunction

    task automatic wait_drained();
        while (pending_dets.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_thresh(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        iou_thresh = v;
    endtask

    task automatic queue_run(input int n, input int mode);
        for (int i = 0; i < n; i++)
            pending_dets.push_back(rand_det(i == n - 1, mode));
    endtask

    // stimulus
    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identical boxes, tie scores, zero score, zero size, extremes
        pending_dets.push_back(mk(16'd1000, 16'd1000, 16'd200, 16'd200, 16'd5000, 0));
        pending_dets.push_back(mk(16'd1000, 16'd1000, 16'd200, 16'd200, 16'd5000, 0));
        pending_dets.push_back(mk(16'd1010, 16'd1000, 16'd200, 16'd200, 16'hffff, 0));
        pending_dets.push_back(mk(16'd1000, 16'd1000, 16'd200, 16'd200, 16'd0, 0));
        pending_dets.push_back(mk(16'd500, 16'd500, 16'd0, 16'd0, 16'd300, 0));
        pending_dets.push_back(mk(16'd500, 16'd500, 16'd0, 16'd0, 16'd200, 0));
        pending_dets.push_back(mk(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd1, 0));
        pending_dets.push_back(mk(16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'd2, 0));
        pending_dets.push_back(mk(16'd3000, 16'd3000, 16'd10, 16'd10, 16'd9, 1));
        // single-item run
        pending_dets.push_back(mk(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1));
        wait_drained();

        // extreme thresholds, overlapping boxes
        write_thresh(16'd0);
        queue_run(6, 0);
        wait_drained();
        write_thresh(16'hffff);
        queue_run(6, 0);
        wait_drained();

        // capacity: 66 items, last two dropped, overflow reported
        write_thresh(16'd32768);
        queue_run(N_DETS + 2, 0);
        wait_drained();

        // random runs with occasional threshold changes
        while (sent_count < 260) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                write_thresh(($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(16000, 45000)));
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
            queue_run(n, ($urandom_range(0, 3) == 0) ? 1 : 0);
            if ($urandom_range(0, 5) == 0) begin
                hold_sender = 1'b1;
                while (start || expected_results.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            while (pending_dets.size() > 0) @(posedge i_clk);
        end
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
